[rtl/core/ordered_list_insert_remove_assert.svh]
// Assertion macros shared by the list block.
`ifndef ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH
`define ORDERED_LIST_INSERT_REMOVE_ASSERT_SVH

// Check in the same cycle that the antecedent holds.
`define OLIR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list check failed");

// Check in the cycle after the antecedent holds.
`define OLIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list check failed");

`endif

[rtl/core/olir_pkg.sv]
package olir_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_READ   = 3'd2;
    localparam logic [2:0] REQ_FIND   = 3'd3;
    localparam logic [2:0] REQ_RMKEY  = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [4:0]  position;
        logic [31:0] word_in;
    } in_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] word_out;
        logic [3:0]  found_position;
        logic [4:0]  count;
    } out_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_SHIFT,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

endpackage

[rtl/core/olir_cell.sv]
module olir_cell #(
    parameter int DEPTH     = olir_pkg::DEPTH_DEF,
    parameter int WORD_BITS = olir_pkg::WORD_BITS_DEF
) (
    input  logic                     clk,
    input  olir_pkg::cell_op_t       op,
    input  logic [$clog2(DEPTH)-1:0] pos,
    input  logic [$clog2(DEPTH)-1:0] index,
    input  logic [WORD_BITS-1:0]     key,
    input  logic [WORD_BITS-1:0]     word,
    input  logic [WORD_BITS-1:0]     left_entry,
    input  logic [WORD_BITS-1:0]     right_entry,
    input  logic [WORD_BITS-1:0]     right_scan,
    input  logic                     right_hit,
    output logic [WORD_BITS-1:0]     entry,
    output logic [WORD_BITS-1:0]     scan,
    output logic                     hit
);

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] scan_reg;
    logic                 hit_reg;

    always_ff @(posedge clk)
    begin
        case (op)
            olir_pkg::CELL_LOAD:
            begin
                scan_reg <= entry_reg;
                hit_reg  <= (entry_reg == key);
            end
            olir_pkg::CELL_SHIFT:
            begin
                scan_reg <= right_scan;
                hit_reg  <= right_hit;
            end
            olir_pkg::CELL_INSERT:
            begin
                // open a gap at pos: cells above take the word below them
                if (index > pos)
                begin
                    entry_reg <= left_entry;
                end
                else if (index == pos)
                begin
                    entry_reg <= word;
                end
            end
            olir_pkg::CELL_REMOVE:
            begin
                // close the gap: cells from pos upward take the word above
                if (index >= pos)
                begin
                    entry_reg <= right_entry;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign entry = entry_reg;
    assign scan  = scan_reg;
    assign hit   = hit_reg;

endmodule

[rtl/core/ordered_list_insert_remove.sv]
// Bounded ordered list held in a row of cells, one word per cell. A request
// is taken when start is high and busy is low; its result appears on result
// for exactly one cycle with done high and must be captured then, as the
// receiver cannot stall the block. On acceptance every cell copies its word
// and its key comparison into a scan row, which then moves one cell towards
// the head per cycle. A request stops at list position k (the position read
// or removed, the first match, or the count when nothing is found); insert,
// spare request codes and any out-of-range request stop without shifting.
// Shifting for insert and remove is done by all cells together in the final
// scan cycle.
`include "ordered_list_insert_remove_assert.svh"

module ordered_list_insert_remove #(
    parameter int DEPTH     = olir_pkg::DEPTH_DEF,
    parameter int WORD_BITS = olir_pkg::WORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  olir_pkg::in_t request,
    output logic          done,
    output olir_pkg::out_t result
);

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   k_reg, k_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            done_reg;
    olir_pkg::out_t  result_reg, result_next;
    logic [2:0]      req_reg;
    logic [4:0]      pos_reg;
    logic [WORD_BITS-1:0] key_reg;

    olir_pkg::cell_op_t cell_op;
    logic [IW-1:0]      cell_pos;
    logic               finish;

    logic [WORD_BITS-1:0] entry_w [DEPTH];
    logic [WORD_BITS-1:0] scan_w  [DEPTH];
    logic                 hit_w   [DEPTH];

    logic [WORD_BITS-1:0] word_key;
    logic [CMPW-1:0]      pos_ext, count_ext, k_ext;

    assign word_key  = request.word_in[WORD_BITS-1:0];
    assign pos_ext   = CMPW'(pos_reg);
    assign count_ext = CMPW'(count_reg);
    assign k_ext     = CMPW'(k_reg);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [WORD_BITS-1:0] left_e, right_e, right_s;
            logic                 right_h;

            if (i == 0)
            begin : g_head
                assign left_e = '0;
            end
            else
            begin : g_body
                assign left_e = entry_w[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_e = '0;
                assign right_s = '0;
                assign right_h = 1'b0;
            end
            else
            begin : g_inner
                assign right_e = entry_w[i+1];
                assign right_s = scan_w[i+1];
                assign right_h = hit_w[i+1];
            end

            olir_cell #(
                .DEPTH     (DEPTH),
                .WORD_BITS (WORD_BITS)
            ) u_cell (
                .clk         (clk),
                .op          (cell_op),
                .pos         (cell_pos),
                .index       (IW'(i)),
                .key         (word_key),
                .word        (key_reg),
                .left_entry  (left_e),
                .right_entry (right_e),
                .right_scan  (right_s),
                .right_hit   (right_h),
                .entry       (entry_w[i]),
                .scan        (scan_w[i]),
                .hit         (hit_w[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        cell_op     = olir_pkg::CELL_HOLD;
        cell_pos    = IW'(pos_reg);
        finish      = 1'b0;
        result_next = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cell_op    = olir_pkg::CELL_LOAD;
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                case (req_reg)
                    olir_pkg::REQ_INSERT:
                    begin
                        finish = 1'b1;
                        if (pos_ext <= count_ext && count_reg < CW'(DEPTH))
                        begin
                            result_next.ok = 1'b1;
                            cell_op        = olir_pkg::CELL_INSERT;
                            count_next     = count_reg + 1'b1;
                        end
                    end
                    olir_pkg::REQ_REMOVE, olir_pkg::REQ_READ:
                    begin
                        if (pos_ext >= count_ext)
                        begin
                            finish = 1'b1;
                        end
                        else if (k_ext == pos_ext)
                        begin
                            finish               = 1'b1;
                            result_next.ok       = 1'b1;
                            result_next.word_out = 32'(scan_w[0]);
                            if (req_reg == olir_pkg::REQ_REMOVE)
                            begin
                                cell_op    = olir_pkg::CELL_REMOVE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            cell_op = olir_pkg::CELL_SHIFT;
                            k_next  = k_reg + 1'b1;
                        end
                    end
                    olir_pkg::REQ_FIND, olir_pkg::REQ_RMKEY:
                    begin
                        if (k_reg >= count_reg)
                        begin
                            finish = 1'b1;
                        end
                        else if (hit_w[0])
                        begin
                            finish                     = 1'b1;
                            result_next.ok             = 1'b1;
                            result_next.found_position = 4'(k_reg);
                            if (req_reg == olir_pkg::REQ_RMKEY)
                            begin
                                result_next.word_out = 32'(scan_w[0]);
                                cell_op              = olir_pkg::CELL_REMOVE;
                                cell_pos             = IW'(k_reg);
                                count_next           = count_reg - 1'b1;
                            end
                        end
                        else
                        begin
                            cell_op = olir_pkg::CELL_SHIFT;
                            k_next  = k_reg + 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
                result_next.count = 5'(count_next);
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            count_reg <= count_next;
            done_reg  <= finish;
        end
    end

    // hold the request word while it is scanned
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg <= request.req_type;
            pos_reg <= request.position;
            key_reg <= word_key;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `OLIR_ASSERT_NOW(a_done_idle, done, !busy)
    `OLIR_ASSERT_NEXT(a_accept_scan, start && !busy, busy && !done)
    `OLIR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `OLIR_ASSERT_NOW(a_fail_zero, done && !result.ok, result.word_out == 32'd0)

endmodule

[verif/tb_ordered_list_insert_remove.sv]
module tb_ordered_list_insert_remove;
    import olir_pkg::*;

    localparam int          LIST_DEPTH      = DEPTH_DEF;
    localparam int          RANDOM_WORDS    = 1450;
    localparam int unsigned CYCLE_LIMIT     = 600000;
    localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;
    localparam logic [31:0] DUP_WORD        = 32'hC0DE_0042;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    in_t  request;
    out_t result;

    // shadow of the list contents, updated as each word is accepted
    logic [31:0] list_words [LIST_DEPTH];
    int unsigned list_len;
    out_t        pending_results [$];
    int          fault_count;
    int unsigned cycle_count;
    int unsigned fill_goal;
    bit          quiet_run;

    ordered_list_insert_remove uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic in_t make_req(logic [2:0] op, logic [4:0] pos, logic [31:0] w);
        in_t r;
        r.req_type = op;
        r.position = pos;
        r.word_in  = w;
        return r;
    endfunction

    function automatic void drop_entry(int unsigned at);
        int unsigned k;
        for (k = at; k + 1 < list_len; k++)
            list_words[k] = list_words[k + 1];
        list_len--;
    endfunction

    function automatic out_t apply_request(in_t req);
        out_t        r;
        int unsigned k;
        int          hit;
        r   = '0;
        hit = -1;
        if (req.req_type == REQ_FIND || req.req_type == REQ_RMKEY)
        begin
            for (k = 0; k < list_len; k++)
                if (hit < 0 && list_words[k] == req.word_in)
                    hit = k;
        end
        case (req.req_type)
            REQ_INSERT:
                if (req.position <= list_len && list_len < LIST_DEPTH)
                begin
                    for (k = list_len; k > req.position; k--)
                        list_words[k] = list_words[k - 1];
                    list_words[req.position] = req.word_in;
                    list_len++;
                    r.ok = 1'b1;
                end
            REQ_REMOVE, REQ_READ:
                if (req.position < list_len)
                begin
                    r.ok       = 1'b1;
                    r.word_out = list_words[req.position];
                    if (req.req_type == REQ_REMOVE)
                        drop_entry(req.position);
                end
            REQ_FIND, REQ_RMKEY:
                if (hit >= 0)
                begin
                    r.ok             = 1'b1;
                    r.found_position = hit[3:0];
                    if (req.req_type == REQ_RMKEY)
                    begin
                        r.word_out = list_words[hit];
                        drop_entry(hit);
                    end
                end
            default: ;
        endcase
        r.count = list_len[4:0];
        return r;
    endfunction

    function automatic int unsigned idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        // a small pool gives plenty of duplicate keys
        if (r < 35)
            return $urandom_range(0, 7);
        if (r < 45)
        begin
            case ($urandom_range(0, 2))
                0:       return 32'hFFFF_FFFF;
                1:       return 32'h0;
                default: return 32'h1 << $urandom_range(0, 31);
            endcase
        end
        return $urandom;
    endfunction

    function automatic in_t random_request();
        int          r;
        bit          grow;
        logic [2:0]  op;
        logic [4:0]  pos;
        logic [31:0] w;
        r    = $urandom_range(0, 99);
        grow = list_len < fill_goal;
        if (r < 3)
            op = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        else if (r < (grow ? 50 : 23))
            op = REQ_INSERT;
        else if (r < (grow ? 62 : 50))
            op = REQ_REMOVE;
        else if (r < 75)
            op = REQ_READ;
        else if (r < 87)
            op = REQ_FIND;
        else
            op = REQ_RMKEY;

        if ($urandom_range(0, 9) == 0 || (list_len == 0 && op != REQ_INSERT))
            pos = 5'($urandom_range(0, 31));
        else if (op == REQ_INSERT)
            pos = 5'($urandom_range(0, list_len));
        else
            pos = 5'($urandom_range(0, list_len - 1));

        // search mostly for keys that are held
        if ((op == REQ_FIND || op == REQ_RMKEY) && list_len != 0 &&
            $urandom_range(0, 3) != 0)
            w = list_words[$urandom_range(0, list_len - 1)];
        else
            w = pick_word();
        return make_req(op, pos, w);
    endfunction

    task automatic send_word(in_t req);
        int unsigned gap;
        request <= req;
        start   <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_request(req));
        gap = quiet_run ? 0 : idle_length();
        if (gap != 0)
        begin
            start   <= 1'b0;
            request <= make_req(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                                $urandom);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            fault_count++;
            $display("%0t: %s expected %h got %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        logic seen_done;
        out_t seen;
        out_t want;
        seen_done = rst_n & done;
        seen      = result;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            // compare after the sender has queued any word accepted at this edge
            #1;
            if (seen_done)
            begin
                if (pending_results.size() == 0)
                begin
                    fault_count++;
                    $display("%0t: unexpected result, expected none, got %h", $time, seen);
                end
                else
                begin
                    want = pending_results.pop_front();
                    report_field("ok", 32'(want.ok), 32'(seen.ok));
                    report_field("word_out", want.word_out, seen.word_out);
                    report_field("found_position", 32'(want.found_position),
                                 32'(seen.found_position));
                    report_field("count", 32'(want.count), 32'(seen.count));
                end
            end
        end
    end

    task automatic test_empty_store();
        send_word(make_req(REQ_REMOVE, 31, 32'h0));
        send_word(make_req(REQ_READ, 0, 32'hFFFF_FFFF));
        send_word(make_req(REQ_FIND, 0, 32'h0));
        send_word(make_req(REQ_RMKEY, 0, 32'hFFFF_FFFF));
        send_word(make_req(REQ_INSERT, 1, 32'h1234_5678));
    endtask

    task automatic test_fill_and_overflow();
        int          i;
        logic [4:0]  pos;
        logic [31:0] w;
        for (i = 0; i < LIST_DEPTH; i++)
        begin
            case (i % 3)
                0:       pos = 0;
                1:       pos = 5'(list_len);
                default: pos = 5'(list_len / 2);
            endcase
            if (i == 0)
                w = 32'hFFFF_FFFF;
            else if (i == 1)
                w = 32'h0;
            else if (i % 4 == 2)
                w = DUP_WORD;
            else
                w = $urandom;
            send_word(make_req(REQ_INSERT, pos, w));
        end
        send_word(make_req(REQ_INSERT, 0, 32'hDEAD_BEEF));
        send_word(make_req(REQ_READ, 5'(LIST_DEPTH - 1), 32'h0));
        send_word(make_req(REQ_READ, 5'(LIST_DEPTH), 32'h0));
    endtask

    task automatic test_search_and_spare_codes();
        send_word(make_req(REQ_FIND, 0, DUP_WORD));
        send_word(make_req(REQ_FIND, 0, 32'h1357_9BDF));
        send_word(make_req(REQ_RMKEY, 0, DUP_WORD));
        send_word(make_req(REQ_RMKEY, 0, 32'hFFFF_FFFF));
        send_word(make_req(REQ_SPARE_FIRST, 0, 32'h0));
        send_word(make_req(REQ_SPARE_LAST, 31, 32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic();
        int n;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            // steer the fill level so that runs reach both empty and full
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       fill_goal = 0;
                    1:       fill_goal = 3;
                    2:       fill_goal = 8;
                    3:       fill_goal = LIST_DEPTH - 2;
                    default: fill_goal = LIST_DEPTH;
                endcase
                quiet_run = $urandom_range(0, 4) == 0;
            end
            send_word(random_request());
        end
        quiet_run = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        fault_count = 0;
        cycle_count = 0;
        list_len    = 0;
        fill_goal   = 0;
        quiet_run   = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_fill_and_overflow();
        test_search_and_spare_codes();
        test_random_traffic();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LIST_DEPTH + 4) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
